// ----- hdl/gps_utc_to_local_time_date_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the UTC to local time converter.
// Each macro expands to one labeled concurrent assertion with its own message.
// ----------------------------------------------------------------------------
`ifndef GPS_UTC_TO_LOCAL_TIME_DATE_TOP_ASSERT_SVH
`define GPS_UTC_TO_LOCAL_TIME_DATE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define GUTLD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GUTLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gutld_pkg.sv -----
// ----------------------------------------------------------------------------
// gutld_pkg
// Shared types and constants of the UTC to local time and date converter.
// ----------------------------------------------------------------------------
package gutld_pkg;

    // Item kind codes.
    typedef enum logic {
        MODE_TIME = 1'b0,
        MODE_DATE = 1'b1
    } t_mode;

    localparam logic [4:0] HOURS_AHEAD_RST = 5'd8;
    localparam logic [5:0] HOURS_PER_DAY   = 6'd24;
    localparam logic [4:0] LAST_MONTH      = 5'd12;
    localparam logic [7:0] YEARS_PER_CENT  = 8'd100;

    // One input word.
    typedef struct packed {
        t_mode      mode;
        logic [4:0] utc_hour;
        logic [5:0] utc_minute;
        logic [5:0] utc_second;
        logic [4:0] utc_day;
        logic [3:0] utc_month;
        logic [6:0] utc_year;
    } t_in_word;

    // One result word.
    typedef struct packed {
        t_mode      result_kind;
        logic [4:0] local_hour;
        logic [5:0] local_minute;
        logic [5:0] local_second;
        logic       minute_alarm;
        logic [4:0] local_day;
        logic [3:0] local_month;
        logic [6:0] local_year;
    } t_out_word;

    // Tracking state carried from item to item.
    typedef struct packed {
        logic       day_pending;
        logic [3:0] last_digit;
        logic       minute_seen;
    } t_track;

endpackage

// ----- hdl/gutld_core.sv -----
// ----------------------------------------------------------------------------
// gutld_core
// Combinational conversion of one word: hour offset, minute alarm tracking
// and the one-day date advance with month lengths and leap years.
// ----------------------------------------------------------------------------
module gutld_core (
    input  gutld_pkg::t_in_word  i_word,
    input  logic [4:0]           i_hours_ahead,
    input  gutld_pkg::t_track    i_track,
    output gutld_pkg::t_out_word o_word,
    output gutld_pkg::t_track    o_track
);
    import gutld_pkg::*;

    // Ones digit of a minute value up to 63.
    function automatic logic [3:0] ones_digit(input logic [5:0] m);
        logic [5:0] r;
        begin
            if (m >= 6'd60) begin
                r = m - 6'd60;
            end else if (m >= 6'd50) begin
                r = m - 6'd50;
            end else if (m >= 6'd40) begin
                r = m - 6'd40;
            end else if (m >= 6'd30) begin
                r = m - 6'd30;
            end else if (m >= 6'd20) begin
                r = m - 6'd20;
            end else if (m >= 6'd10) begin
                r = m - 6'd10;
            end else begin
                r = m;
            end
            return r[3:0];
        end
    endfunction

    // Days in a month; years 2000 to 2127, where only 2100 breaks the rule of four.
    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic [6:0] yr);
        logic leap;
        begin
            leap = (yr[1:0] == 2'd0) && (yr != 7'd100);
            case (mon)
                4'd2:    return leap ? 5'd29 : 5'd28;
                4'd4,
                4'd6,
                4'd9,
                4'd11:   return 5'd30;
                default: return 5'd31;
            endcase
        end
    endfunction

    logic [5:0] hour_sum;
    logic [5:0] hour_mod;
    logic       rollover;
    logic [3:0] digit;
    logic       alarm;
    logic [5:0] day_inc;
    logic [4:0] mon_inc;
    logic [4:0] day_new;
    logic [3:0] mon_new;
    logic       yr_carry;
    logic [7:0] yr_sum;
    logic [7:0] yr_new;

    // Hour offset, reduced modulo one day.
    always_comb begin
        hour_sum = {1'b0, i_word.utc_hour} + {1'b0, i_hours_ahead};
        rollover = (hour_sum >= HOURS_PER_DAY);
        if (hour_sum >= {HOURS_PER_DAY[4:0], 1'b0}) begin
            hour_mod = hour_sum - {HOURS_PER_DAY[4:0], 1'b0};
        end else if (rollover) begin
            hour_mod = hour_sum - HOURS_PER_DAY;
        end else begin
            hour_mod = hour_sum;
        end
    end

    // Minute digit alarm.
    always_comb begin
        digit = ones_digit(i_word.utc_minute);
        alarm = !i_track.minute_seen || (digit > i_track.last_digit);
    end

    // Date advance by one day when a rollover is pending.
    always_comb begin
        day_inc  = {1'b0, i_word.utc_day} + 6'd1;
        mon_inc  = {1'b0, i_word.utc_month} + 5'd1;
        day_new  = day_inc[4:0];
        mon_new  = i_word.utc_month;
        yr_carry = 1'b0;
        if (day_inc > {1'b0, month_days(i_word.utc_month, i_word.utc_year)}) begin
            day_new = 5'd1;
            if (mon_inc > LAST_MONTH) begin
                mon_new  = 4'd1;
                yr_carry = 1'b1;
            end else begin
                mon_new = mon_inc[3:0];
            end
        end
        yr_sum = {1'b0, i_word.utc_year} + {7'd0, yr_carry};
        yr_new = (yr_sum >= YEARS_PER_CENT) ? (yr_sum - YEARS_PER_CENT) : yr_sum;
    end

    // Result word and next tracking state.
    always_comb begin
        o_word             = '0;
        o_word.result_kind = i_word.mode;
        o_track            = i_track;
        if (i_word.mode == MODE_TIME) begin
            o_word.local_hour   = hour_mod[4:0];
            o_word.local_minute = i_word.utc_minute;
            o_word.local_second = i_word.utc_second;
            o_word.minute_alarm = alarm;
            o_track.day_pending = rollover;
            if (digit == 4'd9) begin
                o_track.minute_seen = 1'b0;
                o_track.last_digit  = 4'd0;
            end else begin
                o_track.minute_seen = 1'b1;
                o_track.last_digit  = digit;
            end
        end else if (i_track.day_pending) begin
            o_word.local_day   = day_new;
            o_word.local_month = mon_new;
            o_word.local_year  = yr_new[6:0];
        end else begin
            o_word.local_day   = i_word.utc_day;
            o_word.local_month = i_word.utc_month;
            o_word.local_year  = i_word.utc_year;
        end
    end

endmodule

// ----- hdl/gps_utc_to_local_time_date_top.sv -----
// ----------------------------------------------------------------------------
// gps_utc_to_local_time_date_top
// Converts GPS UTC time and date words to local time and date.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Word
//  in        input      i_in_valid / o_in_ready     t_in_word
//  out       output     o_out_valid / i_out_ready   t_out_word
//  cfg       input      i_cfg_valid / o_cfg_ready   hours_ahead, 5 bits
//
//  One word per cycle while the output is not stalled; each word passes
//  an input register and then a result register. The conversion between
//  the two registers is one pass of short logic. A stall on the output
//  holds both registers; the input register refills as soon as the result
//  register moves on. Reset empties both stages, clears the tracking state
//  and loads an offset of eight hours.
// ----------------------------------------------------------------------------
module gps_utc_to_local_time_date_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gutld_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gutld_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [4:0]           i_cfg_data
);
    import gutld_pkg::*;

    `include "gps_utc_to_local_time_date_top_assert.svh"

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic [4:0] r_hours_ahead;
    t_track    r_track;
    t_track    n_track;
    t_out_word n_out_word;
    logic      advance;

    // Conversion logic between the two registers.
    gutld_core u_core (
        .i_word        (r_in_word),
        .i_hours_ahead (r_hours_ahead),
        .i_track       (r_track),
        .o_word        (n_out_word),
        .o_track       (n_track)
    );

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // Result register and tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_track     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_track     <= n_track;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    // Offset register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours_ahead <= HOURS_AHEAD_RST;
        end else if (i_cfg_valid) begin
            r_hours_ahead <= i_cfg_data;
        end
    end

    // The tracker holds digit zero whenever no minute is being tracked.
    `GUTLD_ASSERT_NOW(a_tracker_clear, i_clk, i_rst_n, !r_track.minute_seen, r_track.last_digit == 4'd0, "minute tracker not cleared")

    // A time result always carries an hour within the day.
    `GUTLD_ASSERT_NOW(a_hour_range, i_clk, i_rst_n, r_out_valid && (r_out_word.result_kind == MODE_TIME), r_out_word.local_hour < HOURS_PER_DAY[4:0], "local hour out of range")

    // Without a pending rollover a date passes through unchanged.
    `GUTLD_ASSERT_NEXT(a_date_pass, i_clk, i_rst_n, advance && (r_in_word.mode == MODE_DATE) && !r_track.day_pending, r_out_word.local_day == $past(r_in_word.utc_day), "date changed without rollover")

    // The input side only stalls when both stages are full and the output is stalled.
    `GUTLD_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_in_ready, r_in_valid && r_out_valid && !i_out_ready, "input stalled without cause")

endmodule
